// File: rtl/core/mmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmp_pkg
// Shared types, byte codes and event codes for the MIDI message parser.
// ----------------------------------------------------------------------------
package mmp_pkg;

    // Default SysEx store depth in bytes
    localparam int SYSEX_DEPTH_DEF = 512;

    // func codes
    localparam logic FUNC_PARSE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // MIDI byte codes
    localparam logic [7:0] ST_SYSEX    = 8'hF0;
    localparam logic [7:0] ST_MTC      = 8'hF1;
    localparam logic [7:0] ST_SONGPOS  = 8'hF2;
    localparam logic [7:0] ST_SONGSEL  = 8'hF3;
    localparam logic [7:0] ST_TUNE     = 8'hF6;
    localparam logic [7:0] ST_EOX      = 8'hF7;
    localparam logic [7:0] ST_RT_BASE  = 8'hF8;
    localparam logic [3:0] HI_PROGRAM  = 4'hC;
    localparam logic [3:0] HI_CHAN_AT  = 4'hD;

    // Event kinds
    localparam logic [4:0] EV_UNKNOWN  = 5'd0;
    localparam logic [4:0] EV_CLOCK    = 5'd1;
    localparam logic [4:0] EV_TICK     = 5'd2;
    localparam logic [4:0] EV_START    = 5'd3;
    localparam logic [4:0] EV_CONTINUE = 5'd4;
    localparam logic [4:0] EV_STOP     = 5'd5;
    localparam logic [4:0] EV_SENSING  = 5'd6;
    localparam logic [4:0] EV_RESET    = 5'd7;
    localparam logic [4:0] EV_SYSEX    = 5'd8;
    localparam logic [4:0] EV_TUNE     = 5'd9;
    localparam logic [4:0] EV_TIMECODE = 5'd10;
    localparam logic [4:0] EV_SONGPOS  = 5'd11;
    localparam logic [4:0] EV_SONGSEL  = 5'd12;
    localparam logic [4:0] EV_NOTEOFF  = 5'd13;

    // One result beat plus read bookkeeping
    typedef struct packed {
        logic [4:0] event_kind;
        logic [3:0] channel;
        logic [7:0] first_data;
        logic [6:0] second_data;
        logic [7:0] msg_status;
        logic [9:0] msg_length;
        logic       high_priority;
        logic [1:0] source_tag;
        logic       is_read;
        logic       in_range;
    } mmp_result_t;

    // Realtime byte F8..FF to event kind, by low three bits
    function automatic logic [4:0] rt_kind(input logic [2:0] lo);
        logic [4:0] k;
        unique case (lo)
            3'd0:    k = EV_CLOCK;
            3'd1:    k = EV_TICK;
            3'd2:    k = EV_START;
            3'd3:    k = EV_CONTINUE;
            3'd4:    k = EV_STOP;
            3'd5:    k = EV_UNKNOWN;
            3'd6:    k = EV_SENSING;
            default: k = EV_RESET;
        endcase
        return k;
    endfunction

    function automatic logic is_high_prio(input logic [4:0] k);
        return (k == EV_CLOCK) || (k == EV_START) || (k == EV_STOP);
    endfunction

endpackage

// File: rtl/core/mmp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AW  = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/mmp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmp_parser
// Byte decoder: running status, system common collection, SysEx framing.
// Drives the SysEx store write and read ports and builds at most one result per beat.
// ----------------------------------------------------------------------------
module mmp_parser
    import mmp_pkg::*;
#(
    parameter int SYSEX_DEPTH = SYSEX_DEPTH_DEF,
    localparam int AW = $clog2(SYSEX_DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic          func,
    input  logic [7:0]    in_byte,
    input  logic [1:0]    source,
    input  logic [8:0]    read_index,
    output logic          res_valid,
    output mmp_result_t   res,
    output logic          ram_we,
    output logic [AW-1:0] ram_waddr,
    output logic [7:0]    ram_wdata,
    output logic          ram_re,
    output logic [AW-1:0] ram_raddr
);

    localparam int FW = $clog2(SYSEX_DEPTH + 1);
    localparam int CW = ((FW > 9) ? FW : 9) + 1;

    logic [7:0]    rs_reg,    rs_next;
    logic [1:0]    vexp_reg,  vexp_next;
    logic [1:0]    vcnt_reg,  vcnt_next;
    logic [6:0]    vdata_reg [2];
    logic [6:0]    vdata_next [2];
    logic [7:0]    cstat_reg, cstat_next;
    logic [1:0]    cexp_reg,  cexp_next;
    logic [1:0]    ccnt_reg,  ccnt_next;
    logic [6:0]    cdata_reg [2];
    logic [6:0]    cdata_next [2];
    logic          act_reg,   act_next;
    logic [FW-1:0] fill_reg,  fill_next;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_reg    <= '0;
            vexp_reg  <= '0;
            vcnt_reg  <= '0;
            vdata_reg <= '{default: '0};
            cstat_reg <= '0;
            cexp_reg  <= '0;
            ccnt_reg  <= '0;
            cdata_reg <= '{default: '0};
            act_reg   <= 1'b0;
            fill_reg  <= '0;
        end
        else
        begin
            rs_reg    <= rs_next;
            vexp_reg  <= vexp_next;
            vcnt_reg  <= vcnt_next;
            vdata_reg <= vdata_next;
            cstat_reg <= cstat_next;
            cexp_reg  <= cexp_next;
            ccnt_reg  <= ccnt_next;
            cdata_reg <= cdata_next;
            act_reg   <= act_next;
            fill_reg  <= fill_next;
        end
    end

    // Decode one beat
    always_comb
    begin
        logic [1:0]    cnt;
        logic [FW-1:0] fill_inc;
        logic [7:0]    b;

        b          = in_byte;
        cnt        = '0;
        fill_inc   = fill_reg + FW'(1);

        rs_next    = rs_reg;
        vexp_next  = vexp_reg;
        vcnt_next  = vcnt_reg;
        vdata_next = vdata_reg;
        cstat_next = cstat_reg;
        cexp_next  = cexp_reg;
        ccnt_next  = ccnt_reg;
        cdata_next = cdata_reg;
        act_next   = act_reg;
        fill_next  = fill_reg;

        res_valid  = 1'b0;
        res        = '0;
        res.source_tag = source;
        ram_we     = 1'b0;
        ram_waddr  = fill_reg[AW-1:0];
        ram_wdata  = b;
        ram_re     = 1'b0;
        ram_raddr  = AW'(read_index);

        if (accept)
        begin
            if (func == FUNC_READ)
            begin
                // Store read: every field but is_read and in_range is zero
                res_valid    = 1'b1;
                res          = '0;
                res.is_read  = 1'b1;
                res.in_range = CW'(read_index) < CW'(SYSEX_DEPTH);
                ram_re       = 1'b1;
            end
            else if (b >= ST_RT_BASE)
            begin
                // Realtime: immediate, state untouched
                res_valid         = 1'b1;
                res.event_kind    = rt_kind(b[2:0]);
                res.high_priority = is_high_prio(res.event_kind);
                res.msg_status    = b;
                res.msg_length    = 10'd1;
            end
            else if (b == ST_SYSEX)
            begin
                // SysEx start (also restarts an open one)
                rs_next   = '0;
                act_next  = 1'b1;
                ram_we    = 1'b1;
                ram_waddr = '0;
                fill_next = FW'(1);
            end
            else if (act_reg)
            begin
                if (fill_reg >= FW'(SYSEX_DEPTH))
                begin
                    // Overflow: drop the message and this byte
                    act_next  = 1'b0;
                    fill_next = '0;
                end
                else
                begin
                    ram_we    = 1'b1;
                    fill_next = fill_inc;
                    if (b == ST_EOX)
                    begin
                        act_next       = 1'b0;
                        fill_next      = '0;
                        res_valid      = 1'b1;
                        res.event_kind = EV_SYSEX;
                        res.msg_status = ST_SYSEX;
                        res.msg_length = 10'(fill_inc);
                    end
                end
            end
            else if (b >= ST_SYSEX)
            begin
                // System common status or stray EOX
                rs_next = '0;
                if (b == ST_EOX)
                begin
                    res_valid      = 1'b1;
                    res.event_kind = EV_UNKNOWN;
                    res.first_data = ST_EOX;
                    res.msg_status = ST_EOX;
                    res.msg_length = 10'd1;
                end
                else
                begin
                    ccnt_next = '0;
                    if (b == ST_MTC || b == ST_SONGSEL)
                    begin
                        cstat_next = b;
                        cexp_next  = 2'd1;
                    end
                    else if (b == ST_SONGPOS)
                    begin
                        cstat_next = b;
                        cexp_next  = 2'd2;
                    end
                    else
                    begin
                        cstat_next     = '0;
                        cexp_next      = '0;
                        res_valid      = 1'b1;
                        res.event_kind = (b == ST_TUNE) ? EV_TUNE : EV_UNKNOWN;
                        res.msg_status = b;
                        res.msg_length = 10'd1;
                    end
                end
            end
            else if (cstat_reg != '0)
            begin
                if (b[7])
                begin
                    // Channel status aborts the pending common message
                    cstat_next = '0;
                end
                else
                begin
                    cnt = ccnt_reg;
                    if (ccnt_reg < cexp_reg && ccnt_reg < 2'd2)
                    begin
                        cdata_next[ccnt_reg[0]] = b[6:0];
                        cnt = ccnt_reg + 2'd1;
                    end
                    if (cnt == cexp_reg)
                    begin
                        res_valid = 1'b1;
                        if (cstat_reg == ST_MTC)
                            res.event_kind = EV_TIMECODE;
                        else if (cstat_reg == ST_SONGPOS)
                            res.event_kind = EV_SONGPOS;
                        else if (cstat_reg == ST_SONGSEL)
                            res.event_kind = EV_SONGSEL;
                        else
                            res.event_kind = EV_UNKNOWN;
                        res.first_data  = (cexp_reg >= 2'd1) ? {1'b0, cdata_next[0]} : '0;
                        res.second_data = (cexp_reg >= 2'd2) ? cdata_next[1] : '0;
                        res.msg_status  = cstat_reg;
                        res.msg_length  = 10'(cexp_reg) + 10'd1;
                        cstat_next      = '0;
                        ccnt_next       = '0;
                    end
                    else
                    begin
                        ccnt_next = cnt;
                    end
                end
            end
            else if (b[7])
            begin
                // New channel status
                rs_next   = b;
                vcnt_next = '0;
                vexp_next = (b[7:4] == HI_PROGRAM || b[7:4] == HI_CHAN_AT) ? 2'd1 : 2'd2;
            end
            else if (rs_reg != '0)
            begin
                // Data under running status
                cnt = vcnt_reg;
                if (vcnt_reg < vexp_reg && vcnt_reg < 2'd2)
                begin
                    vdata_next[vcnt_reg[0]] = b[6:0];
                    cnt = vcnt_reg + 2'd1;
                end
                if (cnt == vexp_reg)
                begin
                    res_valid       = 1'b1;
                    res.event_kind  = 5'(EV_NOTEOFF + 5'(rs_reg[6:4]));
                    res.channel     = rs_reg[3:0];
                    res.first_data  = (vexp_reg >= 2'd1) ? {1'b0, vdata_next[0]} : '0;
                    res.second_data = (vexp_reg >= 2'd2) ? vdata_next[1] : '0;
                    res.msg_status  = rs_reg;
                    res.msg_length  = 10'(vexp_reg) + 10'd1;
                    vcnt_next       = '0;
                end
                else
                begin
                    vcnt_next = cnt;
                end
            end
        end
    end

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(SYSEX_DEPTH))
        else $error("SysEx fill beyond store depth");

    a_fill_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !act_reg |-> (fill_reg == '0))
        else $error("SysEx fill nonzero outside a message");

    a_common_exp: assert property (@(posedge clk) disable iff (!rst_n)
        (cstat_reg != '0) |-> (cexp_reg == 2'd1 || cexp_reg == 2'd2))
        else $error("pending common message with bad data count");

endmodule

// File: rtl/core/midi_message_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_message_parser_top
// MIDI 1.0 stream parser with running status and a SysEx byte store.
// ----------------------------------------------------------------------------
// Pipeline: a result beat is registered in the store-read stage (alongside
//   the SysEx store read), then in the output register.
// Throughput: one input beat per cycle; input stalls only when both the
//   store-read stage and the output register are full and output is stalled.
// Reset: parser state and pipeline valids clear; store contents are
//   undefined until written, no clearing pass.
module midi_message_parser_top
    import mmp_pkg::*;
#(
    parameter int SYSEX_DEPTH = SYSEX_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       func,
    input  logic [7:0] in_byte,
    input  logic [1:0] source,
    input  logic [8:0] read_index,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [4:0] event_kind,
    output logic [3:0] channel,
    output logic [7:0] first_data,
    output logic [6:0] second_data,
    output logic [7:0] msg_status,
    output logic [9:0] msg_length,
    output logic       high_priority,
    output logic [1:0] source_tag,
    output logic [7:0] read_data
);

    localparam int AW = $clog2(SYSEX_DEPTH);

    logic          accept;
    logic          res_valid;
    mmp_result_t   res;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic          p_valid_reg, p_valid_next;
    mmp_result_t   p_res_reg;
    logic          p_move;
    logic          o_valid_reg, o_valid_next;
    mmp_result_t   o_res_reg;
    logic [7:0]    o_rdata_reg;

    // Handshake
    assign p_move   = p_valid_reg && (!o_valid_reg || !out_stall);
    assign in_stall = p_valid_reg && !p_move;
    assign accept   = in_valid && !in_stall;

    mmp_parser #(
        .SYSEX_DEPTH (SYSEX_DEPTH)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .func       (func),
        .in_byte    (in_byte),
        .source     (source),
        .read_index (read_index),
        .res_valid  (res_valid),
        .res        (res),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr)
    );

    mmp_ram #(
        .WIDTH (8),
        .DEPTH (SYSEX_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Valid flags next state
    always_comb
    begin
        p_valid_next = p_valid_reg;
        if (accept)
            p_valid_next = res_valid;
        else if (p_move)
            p_valid_next = 1'b0;

        o_valid_next = p_move || (o_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    // Store-read stage and output register payload
    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            p_res_reg <= res;
        end
        if (p_move)
        begin
            o_res_reg   <= p_res_reg;
            o_rdata_reg <= (p_res_reg.is_read && p_res_reg.in_range) ? ram_rdata : 8'd0;
        end
    end

    assign out_valid     = o_valid_reg;
    assign event_kind    = o_res_reg.event_kind;
    assign channel       = o_res_reg.channel;
    assign first_data    = o_res_reg.first_data;
    assign second_data   = o_res_reg.second_data;
    assign msg_status    = o_res_reg.msg_status;
    assign msg_length    = o_res_reg.msg_length;
    assign high_priority = o_res_reg.high_priority;
    assign source_tag    = o_res_reg.source_tag;
    assign read_data     = o_rdata_reg;

    // Checks
    a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (p_valid_reg && o_valid_reg && out_stall) |=> p_valid_reg)
        else $error("pending beat lost while output stalled");

    a_move_fills: assert property (@(posedge clk) disable iff (!rst_n)
        p_move |=> o_valid_reg)
        else $error("beat moved but output register empty");

    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("store write and read in the same cycle");

endmodule

// File: dv/midi_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_event_checker
// Watches both channels of the MIDI message parser, predicts every result
// beat from the accepted input beats and compares it field by field.
// ----------------------------------------------------------------------------
module midi_event_checker
    import mmp_pkg::*;
#(
    parameter int SYSEX_DEPTH = SYSEX_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       func,
    input  logic [7:0] in_byte,
    input  logic [1:0] source,
    input  logic [8:0] read_index,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [4:0] event_kind,
    input  logic [3:0] channel,
    input  logic [7:0] first_data,
    input  logic [6:0] second_data,
    input  logic [7:0] msg_status,
    input  logic [9:0] msg_length,
    input  logic       high_priority,
    input  logic [1:0] source_tag,
    input  logic [7:0] read_data,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic [4:0] kind;
        logic [3:0] chan;
        logic [7:0] d1;
        logic [6:0] d2;
        logic [7:0] status;
        logic [9:0] len;
        logic       hp;
        logic [1:0] src;
        logic [7:0] rdata;
    } midi_event_t;

    // Predicted parser state
    logic [7:0]  run_status;
    logic [1:0]  voice_need;
    logic [1:0]  voice_cnt;
    logic [6:0]  voice_byte [2];
    logic [7:0]  sys_status;
    logic [1:0]  sys_need;
    logic [1:0]  sys_cnt;
    logic [6:0]  sys_byte [2];
    logic        sx_open;
    int          sx_fill;
    logic [7:0]  sx_mem [SYSEX_DEPTH];

    midi_event_t midi_events_due [$];

    assign pending = midi_events_due.size();

    function automatic midi_event_t make_event(input logic [4:0] kind,
                                               input logic [3:0] chan,
                                               input logic [7:0] d1,
                                               input logic [6:0] d2,
                                               input logic [7:0] status,
                                               input logic [9:0] len,
                                               input logic [1:0] src);
        midi_event_t ev;
        ev.kind   = kind;
        ev.chan   = chan;
        ev.d1     = d1;
        ev.d2     = d2;
        ev.status = status;
        ev.len    = len;
        ev.hp     = (kind == EV_CLOCK) || (kind == EV_START) || (kind == EV_STOP);
        ev.src    = src;
        ev.rdata  = 8'h00;
        return ev;
    endfunction

    // Advance the predicted parser by one input beat
    task automatic parse_beat(input logic f, input logic [7:0] b, input logic [1:0] s,
                              input logic [8:0] idx);
        midi_event_t ev;
        logic [4:0]  k;
        if (f == FUNC_READ)
        begin
            ev = '0;
            ev.rdata = (idx < SYSEX_DEPTH) ? sx_mem[idx] : 8'h00;
            midi_events_due.push_back(ev);
            return;
        end
        // realtime: immediate event, state untouched
        if (b >= ST_RT_BASE)
        begin
            case (b[2:0])
                3'd0:    k = EV_CLOCK;
                3'd1:    k = EV_TICK;
                3'd2:    k = EV_START;
                3'd3:    k = EV_CONTINUE;
                3'd4:    k = EV_STOP;
                3'd5:    k = EV_UNKNOWN;
                3'd6:    k = EV_SENSING;
                default: k = EV_RESET;
            endcase
            midi_events_due.push_back(make_event(k, 4'd0, 8'd0, 7'd0, b, 10'd1, s));
            return;
        end
        // SysEx start, also restarts an open message
        if (b == ST_SYSEX)
        begin
            run_status = 8'h00;
            sx_open    = 1'b1;
            sx_mem[0]  = b;
            sx_fill    = 1;
            return;
        end
        if (sx_open)
        begin
            // full store: byte swallowed, message dropped
            if (sx_fill >= SYSEX_DEPTH)
            begin
                sx_open = 1'b0;
                sx_fill = 0;
                return;
            end
            sx_mem[sx_fill] = b;
            sx_fill++;
            if (b == ST_EOX)
            begin
                midi_events_due.push_back(make_event(EV_SYSEX, 4'd0, 8'd0, 7'd0, ST_SYSEX,
                                                     10'(sx_fill), s));
                sx_open = 1'b0;
                sx_fill = 0;
            end
            return;
        end
        // system common and stray EOX
        if (b >= ST_SYSEX)
        begin
            run_status = 8'h00;
            if (b == ST_EOX)
            begin
                midi_events_due.push_back(make_event(EV_UNKNOWN, 4'd0, ST_EOX, 7'd0, ST_EOX,
                                                     10'd1, s));
                return;
            end
            sys_status = b;
            sys_cnt    = 2'd0;
            if (b == ST_MTC || b == ST_SONGSEL)
                sys_need = 2'd1;
            else if (b == ST_SONGPOS)
                sys_need = 2'd2;
            else
                sys_need = 2'd0;
            if (sys_need == 2'd0)
            begin
                k = (b == ST_TUNE) ? EV_TUNE : EV_UNKNOWN;
                midi_events_due.push_back(make_event(k, 4'd0, 8'd0, 7'd0, b, 10'd1, s));
                sys_status = 8'h00;
            end
            return;
        end
        // data for a pending system common message
        if (sys_status != 8'h00)
        begin
            if (b[7])
            begin
                sys_status = 8'h00;
                return;
            end
            if (sys_cnt < sys_need)
            begin
                sys_byte[sys_cnt[0]] = b[6:0];
                sys_cnt++;
            end
            if (sys_cnt != sys_need)
                return;
            if (sys_status == ST_MTC)
                k = EV_TIMECODE;
            else if (sys_status == ST_SONGPOS)
                k = EV_SONGPOS;
            else if (sys_status == ST_SONGSEL)
                k = EV_SONGSEL;
            else
                k = EV_UNKNOWN;
            midi_events_due.push_back(make_event(k, 4'd0,
                (sys_need >= 2'd1) ? {1'b0, sys_byte[0]} : 8'd0,
                (sys_need >= 2'd2) ? sys_byte[1] : 7'd0,
                sys_status, 10'(sys_need) + 10'd1, s));
            sys_status = 8'h00;
            sys_cnt    = 2'd0;
            return;
        end
        // voice status sets running status
        if (b[7])
        begin
            run_status = b;
            voice_cnt  = 2'd0;
            voice_need = (b[7:4] == HI_PROGRAM || b[7:4] == HI_CHAN_AT) ? 2'd1 : 2'd2;
            return;
        end
        // voice data under running status; orphans fall through
        if (run_status != 8'h00)
        begin
            if (voice_cnt < voice_need)
            begin
                voice_byte[voice_cnt[0]] = b[6:0];
                voice_cnt++;
            end
            if (voice_cnt != voice_need)
                return;
            midi_events_due.push_back(make_event(EV_NOTEOFF + {2'b00, run_status[6:4]},
                run_status[3:0],
                (voice_need >= 2'd1) ? {1'b0, voice_byte[0]} : 8'd0,
                (voice_need >= 2'd2) ? voice_byte[1] : 7'd0,
                run_status, 10'(voice_need) + 10'd1, s));
            voice_cnt = 2'd0;
        end
    endtask

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Sample both channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        midi_event_t want;
        if (!rst_n)
        begin
            run_status    = 8'h00;
            voice_need    = 2'd0;
            voice_cnt     = 2'd0;
            voice_byte[0] = 7'd0;
            voice_byte[1] = 7'd0;
            sys_status    = 8'h00;
            sys_need      = 2'd0;
            sys_cnt       = 2'd0;
            sys_byte[0]   = 7'd0;
            sys_byte[1]   = 7'd0;
            sx_open       = 1'b0;
            sx_fill       = 0;
            midi_events_due.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                parse_beat(func, in_byte, source, read_index);
            if (out_valid && !out_stall)
            begin
                if (midi_events_due.size() == 0)
                begin
                    $display("%0t unexpected result beat: expected none, actual kind %0h status %0h",
                             $time, event_kind, msg_status);
                    fail_count++;
                end
                else
                begin
                    want = midi_events_due.pop_front();
                    compare_field("event_kind", want.kind, event_kind);
                    compare_field("channel", want.chan, channel);
                    compare_field("first_data", want.d1, first_data);
                    compare_field("second_data", want.d2, second_data);
                    compare_field("msg_status", want.status, msg_status);
                    compare_field("msg_length", want.len, msg_length);
                    compare_field("high_priority", want.hp, high_priority);
                    compare_field("source_tag", want.src, source_tag);
                    compare_field("read_data", want.rdata, read_data);
                end
            end
        end
    end

    initial fail_count = 0;

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the MIDI message parser: directed beats, then a random mix of
// voice, system common, SysEx, realtime, store reads and noise, with random
// gaps and stalls on both sides. Checking is done in midi_event_checker.
// ----------------------------------------------------------------------------
module tb;
    import mmp_pkg::*;

    localparam int DEPTH       = SYSEX_DEPTH_DEF;
    localparam int MIX_BEATS   = 1070;
    localparam int CYCLE_LIMIT = 1000000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       func;
    logic [7:0] in_byte;
    logic [1:0] source;
    logic [8:0] read_index;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [4:0] event_kind;
    logic [3:0] channel;
    logic [7:0] first_data;
    logic [6:0] second_data;
    logic [7:0] msg_status;
    logic [9:0] msg_length;
    logic       high_priority;
    logic [1:0] source_tag;
    logic [7:0] read_data;

    int fail_count;
    int events_due;
    int cycles = 0;

    // SysEx store coverage seen from the stimulus side (entries 0..store_top-1)
    int   store_top   = 0;
    logic sx_tracking = 1'b0;
    int   sx_count    = 0;

    int beats_sent = 0;
    bit quiet_in   = 1'b0;
    bit quiet_out  = 1'b0;
    bit out_taken  = 1'b0;
    int out_hold   = 0;

    midi_message_parser_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .in_byte       (in_byte),
        .source        (source),
        .read_index    (read_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_kind    (event_kind),
        .channel       (channel),
        .first_data    (first_data),
        .second_data   (second_data),
        .msg_status    (msg_status),
        .msg_length    (msg_length),
        .high_priority (high_priority),
        .source_tag    (source_tag),
        .read_data     (read_data)
    );

    midi_event_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .in_byte       (in_byte),
        .source        (source),
        .read_index    (read_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_kind    (event_kind),
        .channel       (channel),
        .first_data    (first_data),
        .second_data   (second_data),
        .msg_status    (msg_status),
        .msg_length    (msg_length),
        .high_priority (high_priority),
        .source_tag    (source_tag),
        .read_data     (read_data),
        .fail_count    (fail_count),
        .pending       (events_due)
    );

    always #4 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: random stall after each taken beat, with quiet stretches
    always @(posedge clk)
    begin
        out_taken <= out_valid && !out_stall;
    end

    always @(negedge clk)
    begin
        if ($urandom_range(0, 255) == 0)
            quiet_out = ~quiet_out;
        if (out_taken)
            out_hold = quiet_out ? 0 : $urandom_range(0, 16);
        if (out_hold > 0)
        begin
            out_stall <= 1'b1;
            out_hold--;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // One input beat: random gap, then hold until accepted
    task automatic drive_beat(input logic f, input logic [7:0] b, input logic [1:0] s,
                              input logic [8:0] idx);
        int gap;
        gap = quiet_in ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        func       <= f;
        in_byte    <= b;
        source     <= s;
        read_index <= idx;
        // track which store entries get written
        if (f == FUNC_PARSE && b < ST_RT_BASE)
        begin
            if (b == ST_SYSEX)
            begin
                sx_tracking = 1'b1;
                sx_count    = 1;
                if (store_top < 1)
                    store_top = 1;
            end
            else if (sx_tracking)
            begin
                if (sx_count >= DEPTH)
                begin
                    sx_tracking = 1'b0;
                    sx_count    = 0;
                end
                else
                begin
                    sx_count++;
                    if (sx_count > store_top)
                        store_top = sx_count;
                    if (b == ST_EOX)
                    begin
                        sx_tracking = 1'b0;
                        sx_count    = 0;
                    end
                end
            end
        end
        do @(posedge clk); while (in_stall);
        beats_sent++;
        if ($urandom_range(0, 63) == 0)
            quiet_in = ~quiet_in;
    endtask

    task automatic send_byte(input logic [7:0] b);
        drive_beat(FUNC_PARSE, b, 2'($urandom_range(0, 3)), 9'($urandom_range(0, 511)));
    endtask

    task automatic read_store();
        drive_beat(FUNC_READ, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                   9'($urandom_range(0, store_top - 1)));
    endtask

    task automatic send_realtime();
        send_byte(8'($urandom_range(ST_RT_BASE, 8'hFF)));
    endtask

    // SysEx that fills the store exactly, EOX in the last entry; with
    // overflow set, one more body byte leaves no room and the EOX is dropped
    task automatic send_long_sysex(input bit overflow);
        send_byte(ST_SYSEX);
        for (int i = 1; i < DEPTH - 1; i++)
            send_byte(8'($urandom_range(0, 8'hEF)));
        if (overflow)
            send_byte(8'($urandom_range(0, 8'hEF)));
        send_byte(ST_EOX);
    endtask

    logic [7:0] opening [] = '{
        8'hF0, 8'h90, 8'hF3, 8'hF7,         // SysEx carrying status bytes
        8'hF8, 8'hFA, 8'hFC, 8'hFD, 8'hFF,  // realtime incl. undefined FD
        8'h90, 8'h00, 8'h7F, 8'h3C, 8'h00,  // note on, then running status
        8'hC5, 8'h10,                       // program change, one data byte
        8'hF2, 8'h7F, 8'h7F,                // song position, max data
        8'hF1, 8'h90, 8'h40, 8'h01,         // MTC aborted by status, orphan data
        8'hF4, 8'hF6, 8'hF7                 // undefined common, tune, stray EOX
    };

    initial
    begin
        int         pick;
        int         n;
        int         need;
        int         mix_start;
        logic [7:0] st;
        logic [7:0] b;
        bit         long_done;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        func       = FUNC_PARSE;
        in_byte    = 8'h00;
        source     = 2'd0;
        read_index = 9'd0;
        long_done  = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Directed beats
        foreach (opening[i])
            send_byte(opening[i]);
        drive_beat(FUNC_READ, 8'h00, 2'd3, 9'd3);
        drive_beat(FUNC_READ, 8'hFF, 2'd0, 9'd0);

        // Random mix, one store-filling SysEx included
        mix_start = beats_sent;
        while (beats_sent - mix_start < MIX_BEATS)
        begin
            pick = $urandom_range(0, 99);
            if (!long_done && beats_sent - mix_start > 300)
            begin
                send_long_sysex(1'($urandom_range(0, 1)));
                long_done = 1'b1;
            end
            else if (pick < 35)
            begin
                // voice messages under running status, some cut short
                st = 8'($urandom_range(8'h80, 8'hEF));
                need = (st[7:4] == HI_PROGRAM || st[7:4] == HI_CHAN_AT) ? 1 : 2;
                send_byte(st);
                n = $urandom_range(1, 3);
                for (int m = 0; m < n; m++)
                begin
                    for (int j = 0; j < need; j++)
                    begin
                        if ($urandom_range(0, 15) == 0)
                            send_realtime();
                        if ($urandom_range(0, 19) != 0)
                            send_byte(8'($urandom_range(0, 8'h7F)));
                    end
                end
            end
            else if (pick < 47)
            begin
                // system common, occasionally aborted by a voice status
                st = 8'($urandom_range(ST_MTC, ST_TUNE));
                if (st == ST_MTC || st == ST_SONGSEL)
                    need = 1;
                else if (st == ST_SONGPOS)
                    need = 2;
                else
                    need = 0;
                send_byte(st);
                for (int j = 0; j < need; j++)
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        send_byte(8'($urandom_range(8'h80, 8'hEF)));
                        break;
                    end
                    if ($urandom_range(0, 15) == 0)
                        send_realtime();
                    send_byte(8'($urandom_range(0, 8'h7F)));
                end
            end
            else if (pick < 61)
            begin
                // short SysEx with embedded status, realtime and restarts
                send_byte(ST_SYSEX);
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
                for (int j = 0; j < n; j++)
                begin
                    case ($urandom_range(0, 15))
                        0: send_realtime();
                        1: send_byte(ST_SYSEX);
                        2:
                        begin
                            b = 8'($urandom_range(8'h80, ST_TUNE));
                            send_byte((b == ST_SYSEX) ? ST_MTC : b);
                        end
                        default: send_byte(8'($urandom_range(0, 8'h7F)));
                    endcase
                end
                if ($urandom_range(0, 7) != 0)
                    send_byte(ST_EOX);
            end
            else if (pick < 79)
            begin
                n = $urandom_range(1, 4);
                for (int j = 0; j < n; j++)
                    read_store();
            end
            else if (pick < 89)
            begin
                send_realtime();
            end
            else
            begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end

        // Drain
        @(negedge clk);
        in_valid <= 1'b0;
        while (events_due != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/mmp_pkg.sv
rtl/core/mmp_ram.sv
rtl/core/mmp_parser.sv
rtl/core/midi_message_parser_top.sv
dv/midi_event_checker.sv
dv/tb.sv
